FILE: hdl/lms_pkg.sv
// shared constants, codes and types for the led matrix scan driver
// no dependencies
`timescale 1ns / 1ps

package lms_pkg;

    // panel geometry and plane count defaults
    localparam int LMS_COLUMNS    = 64;
    localparam int LMS_ROW_PAIRS  = 16;
    localparam int LMS_BIT_PLANES = 6;

    // bits per color channel
    localparam int LMS_CHAN_BITS  = 8;

    // result queue depth, covers the read stage in flight plus a full stall
    localparam int LMS_OUTQ_DEPTH = 3;

    localparam logic [7:0] LMS_BRIGHT_RESET = 8'h01;

    // scan phase codes
    localparam logic [1:0] PH_DATA_LOW  = 2'd0;
    localparam logic [1:0] PH_DATA_HIGH = 2'd1;
    localparam logic [1:0] PH_LATCH     = 2'd2;
    localparam logic [1:0] PH_LIT       = 2'd3;

    // action codes of an input transfer
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // pin sample controls for one tick, aligned with the store read data
    typedef struct packed {
        logic [3:0] row;
        logic [2:0] bitpos;
        logic       shifting;
        logic       shift_clock;
        logic       latch_strobe;
        logic       blank_n;
    } t_scan_ctl;

    // one pin sample as delivered on the result channel
    typedef struct packed {
        logic [3:0] row_select;
        logic       red_top;
        logic       green_top;
        logic       blue_top;
        logic       red_bottom;
        logic       green_bottom;
        logic       blue_bottom;
        logic       shift_clock;
        logic       latch_strobe;
        logic       blank_n;
    } t_result;

endpackage

FILE: hdl/lms_ifs.sv
// valid/ready channel interfaces: pixel/tick input, pin sample result, brightness write
// no dependencies
`timescale 1ns / 1ps

interface lms_pix_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [10:0] pixel_index;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;

    modport source (
        output valid, action, pixel_index, red_in, green_in, blue_in,
        input  ready
    );
    modport sink (
        input  valid, action, pixel_index, red_in, green_in, blue_in,
        output ready
    );
endinterface

interface lms_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] row_select;
    logic       red_top;
    logic       green_top;
    logic       blue_top;
    logic       red_bottom;
    logic       green_bottom;
    logic       blue_bottom;
    logic       shift_clock;
    logic       latch_strobe;
    logic       blank_n;

    modport source (
        output valid, row_select, red_top, green_top, blue_top,
               red_bottom, green_bottom, blue_bottom,
               shift_clock, latch_strobe, blank_n,
        input  ready
    );
    modport sink (
        input  valid, row_select, red_top, green_top, blue_top,
               red_bottom, green_bottom, blue_bottom,
               shift_clock, latch_strobe, blank_n,
        output ready
    );
endinterface

interface lms_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

FILE: hdl/led_matrix_scan_rgb888.sv
// led matrix scan driver, top level: ports, brightness register, read stage, result queue
// depends on lms_pkg, lms_ifs, lms_store, lms_scan, lms_outq
// one input transfer per cycle sustained while the result channel is ready; a tick's pin
// sample passes the store read and control register, then the three-entry result queue
// reset: the frame store is swept to black, one entry per cycle, over all 2*ROW_PAIRS*COLUMNS
// entries (2048 by default) with input ready low; brightness writes are taken throughout
`timescale 1ns / 1ps

module led_matrix_scan_rgb888 #(
    parameter int COLUMNS    = lms_pkg::LMS_COLUMNS,
    parameter int ROW_PAIRS  = lms_pkg::LMS_ROW_PAIRS,
    parameter int BIT_PLANES = lms_pkg::LMS_BIT_PLANES
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lms_pix_if.sink  i_pix,
    lms_cfg_if.sink  i_cfg,
    lms_res_if.source o_res
);
    import lms_pkg::*;

    localparam int STORE_SIZE = 2 * ROW_PAIRS * COLUMNS;
    localparam int AW         = $clog2(STORE_SIZE);
    localparam int DW         = 3 * LMS_CHAN_BITS;
    localparam int QCW        = $clog2(LMS_OUTQ_DEPTH + 1);

    // brightness register, written at any time the channel asks
    logic [7:0] r_brightness;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= LMS_BRIGHT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_brightness <= i_cfg.data;
        end
    end

    assign i_cfg.ready = 1'b1;

    // input transfer decode
    logic pix_xfer;
    logic tick;
    logic wr_en;
    logic store_busy;

    assign pix_xfer = i_pix.valid && i_pix.ready;
    assign tick     = pix_xfer && (i_pix.action == ACT_TICK);
    // writes beyond the panel are dropped
    assign wr_en    = pix_xfer && (i_pix.action == ACT_WRITE)
                      && (32'(i_pix.pixel_index) < 32'(STORE_SIZE));

    // sequencer gives the read addresses for the current tick and registers its controls
    logic [AW-1:0] rd_addr_top;
    logic [AW-1:0] rd_addr_bot;
    logic          stage_vld;
    t_scan_ctl     stage_ctl;

    lms_scan #(
        .COLUMNS    (COLUMNS),
        .ROW_PAIRS  (ROW_PAIRS),
        .BIT_PLANES (BIT_PLANES),
        .AW         (AW)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (tick),
        .i_brightness  (r_brightness),
        .o_rd_addr_top (rd_addr_top),
        .o_rd_addr_bot (rd_addr_bot),
        .o_vld         (stage_vld),
        .o_ctl         (stage_ctl)
    );

    // frame store; a write lands at its own transfer edge so a following tick sees it
    logic [DW-1:0] top_px;
    logic [DW-1:0] bot_px;

    lms_store #(
        .DEPTH (STORE_SIZE),
        .AW    (AW)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (AW'(i_pix.pixel_index)),
        .i_wr_data   ({i_pix.red_in, i_pix.green_in, i_pix.blue_in}),
        .i_rd_en     (tick),
        .i_rd_addr_a (rd_addr_top),
        .i_rd_addr_b (rd_addr_bot),
        .o_rd_data_a (top_px),
        .o_rd_data_b (bot_px),
        .o_busy      (store_busy)
    );

    // pick the plane bit of each channel; colors are zero outside shifting
    logic [7:0] top_r, top_g, top_b;
    logic [7:0] bot_r, bot_g, bot_b;
    t_result    stage_res;

    assign {top_r, top_g, top_b} = top_px;
    assign {bot_r, bot_g, bot_b} = bot_px;

    always_comb begin
        stage_res.row_select   = stage_ctl.row;
        stage_res.red_top      = stage_ctl.shifting & top_r[stage_ctl.bitpos];
        stage_res.green_top    = stage_ctl.shifting & top_g[stage_ctl.bitpos];
        stage_res.blue_top     = stage_ctl.shifting & top_b[stage_ctl.bitpos];
        stage_res.red_bottom   = stage_ctl.shifting & bot_r[stage_ctl.bitpos];
        stage_res.green_bottom = stage_ctl.shifting & bot_g[stage_ctl.bitpos];
        stage_res.blue_bottom  = stage_ctl.shifting & bot_b[stage_ctl.bitpos];
        stage_res.shift_clock  = stage_ctl.shift_clock;
        stage_res.latch_strobe = stage_ctl.latch_strobe;
        stage_res.blank_n      = stage_ctl.blank_n;
    end

    // result queue decouples the result channel from the input side
    logic          q_valid;
    logic          q_pop;
    t_result       q_data;
    logic [QCW-1:0] q_count;

    assign q_pop = o_res.valid && o_res.ready;

    lms_outq #(
        .DEPTH (LMS_OUTQ_DEPTH),
        .CW    (QCW)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (stage_vld),
        .i_data  (stage_res),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    // accept while queue plus the sample in flight leave a free slot; no path from o_res.ready
    assign i_pix.ready = !store_busy
                         && (({1'b0, q_count} + (QCW + 1)'(stage_vld))
                             < (QCW + 1)'(LMS_OUTQ_DEPTH));

    assign o_res.valid        = q_valid;
    assign o_res.row_select   = q_data.row_select;
    assign o_res.red_top      = q_data.red_top;
    assign o_res.green_top    = q_data.green_top;
    assign o_res.blue_top     = q_data.blue_top;
    assign o_res.red_bottom   = q_data.red_bottom;
    assign o_res.green_bottom = q_data.green_bottom;
    assign o_res.blue_bottom  = q_data.blue_bottom;
    assign o_res.shift_clock  = q_data.shift_clock;
    assign o_res.latch_strobe = q_data.latch_strobe;
    assign o_res.blank_n      = q_data.blank_n;

endmodule

FILE: hdl/lms_store.sv
// rgb888 frame store: one write port, two registered read ports, clearing sweep after reset
// depends on lms_pkg
`timescale 1ns / 1ps

module lms_store #(
    parameter int DEPTH = 2 * lms_pkg::LMS_ROW_PAIRS * lms_pkg::LMS_COLUMNS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [AW-1:0]                     i_wr_addr,
    input  logic [3*lms_pkg::LMS_CHAN_BITS-1:0] i_wr_data,
    input  logic                              i_rd_en,
    input  logic [AW-1:0]                     i_rd_addr_a,
    input  logic [AW-1:0]                     i_rd_addr_b,
    output logic [3*lms_pkg::LMS_CHAN_BITS-1:0] o_rd_data_a,
    output logic [3*lms_pkg::LMS_CHAN_BITS-1:0] o_rd_data_b,
    output logic                              o_busy
);
    import lms_pkg::*;

    localparam int DW = 3 * LMS_CHAN_BITS;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data_a;
    logic [DW-1:0] r_rd_data_b;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;

    // sweep writes black until every entry is done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        wr_en   = r_clr_busy | i_wr_en;
        wr_addr = r_clr_busy ? r_clr_addr : i_wr_addr;
        wr_data = r_clr_busy ? '0 : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data_a <= r_mem[i_rd_addr_a];
            r_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;
    assign o_busy      = r_clr_busy;

endmodule

FILE: hdl/lms_scan.sv
// scan sequencer: plane, row, column and lit counters, store read addresses
// depends on lms_pkg
`timescale 1ns / 1ps

module lms_scan #(
    parameter int COLUMNS    = lms_pkg::LMS_COLUMNS,
    parameter int ROW_PAIRS  = lms_pkg::LMS_ROW_PAIRS,
    parameter int BIT_PLANES = lms_pkg::LMS_BIT_PLANES,
    parameter int AW         = $clog2(2 * ROW_PAIRS * COLUMNS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tick,
    input  logic [7:0]          i_brightness,
    output logic [AW-1:0]       o_rd_addr_top,
    output logic [AW-1:0]       o_rd_addr_bot,
    output logic                o_vld,
    output lms_pkg::t_scan_ctl  o_ctl
);
    import lms_pkg::*;

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROW_PAIRS);
    localparam int PW = (BIT_PLANES > 1) ? $clog2(BIT_PLANES) : 1;
    localparam int LW = 8 + BIT_PLANES - 1;

    logic [1:0]    r_phase, n_phase;
    logic [CW-1:0] r_col,   n_col;
    logic [RW-1:0] r_row,   n_row;
    logic [PW-1:0] r_plane, n_plane;
    logic [LW-1:0] r_lit,   n_lit;
    logic          r_vld;
    t_scan_ctl     r_ctl,   n_ctl;

    logic [LW-1:0] lit_load;

    assign lit_load = LW'(i_brightness) << r_plane;

    always_comb begin
        n_phase = r_phase;
        n_col   = r_col;
        n_row   = r_row;
        n_plane = r_plane;
        n_lit   = r_lit;

        n_ctl.row          = 4'(r_row);
        n_ctl.bitpos       = 3'(r_plane) + 3'(8 - BIT_PLANES);
        n_ctl.shifting     = 1'b0;
        n_ctl.shift_clock  = 1'b0;
        n_ctl.latch_strobe = 1'b0;
        n_ctl.blank_n      = 1'b1;

        unique case (r_phase)
            PH_DATA_LOW: begin
                n_ctl.shifting = 1'b1;
                n_phase        = PH_DATA_HIGH;
            end
            PH_DATA_HIGH: begin
                n_ctl.shifting    = 1'b1;
                n_ctl.shift_clock = 1'b1;
                if (r_col == CW'(COLUMNS - 1)) begin
                    n_col   = '0;
                    n_phase = PH_LATCH;
                end else begin
                    n_col   = r_col + CW'(1);
                    n_phase = PH_DATA_LOW;
                end
            end
            PH_LATCH: begin
                n_ctl.latch_strobe = 1'b1;
                n_lit              = lit_load;
                n_phase            = PH_LIT;
            end
            PH_LIT: begin
                n_ctl.blank_n = 1'b0;
                n_lit         = r_lit - LW'(1);
            end
            default: begin
                n_phase = PH_DATA_LOW;
            end
        endcase

        // row done: zero brightness after latch, or last lit tick
        if ((r_phase == PH_LATCH && i_brightness == 8'd0)
                || (r_phase == PH_LIT && r_lit == LW'(1))) begin
            n_lit   = '0;
            n_col   = '0;
            n_phase = PH_DATA_LOW;
            if (r_row == RW'(ROW_PAIRS - 1)) begin
                n_row   = '0;
                n_plane = (r_plane == PW'(BIT_PLANES - 1)) ? '0 : r_plane + PW'(1);
            end else begin
                n_row = r_row + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DATA_LOW;
            r_col   <= '0;
            r_row   <= '0;
            r_plane <= '0;
            r_lit   <= '0;
            r_vld   <= 1'b0;
        end else begin
            r_vld <= i_tick;
            if (i_tick) begin
                r_phase <= n_phase;
                r_col   <= n_col;
                r_row   <= n_row;
                r_plane <= n_plane;
                r_lit   <= n_lit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick) begin
            r_ctl <= n_ctl;
        end
    end

    assign o_rd_addr_top = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);
    assign o_rd_addr_bot = o_rd_addr_top + AW'(ROW_PAIRS * COLUMNS);
    assign o_vld         = r_vld;
    assign o_ctl         = r_ctl;

endmodule

FILE: hdl/lms_outq.sv
// small result queue between the read stage and the result channel
// depends on lms_pkg
`timescale 1ns / 1ps

module lms_outq #(
    parameter int DEPTH = lms_pkg::LMS_OUTQ_DEPTH,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lms_pkg::t_result i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output lms_pkg::t_result o_data,
    output logic [CW-1:0]    o_count
);
    import lms_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_result       r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

endmodule
